// ----- hw/rtl/erc_pkg.sv -----
// Shared types and constants for the EEPROM register controller.
package erc_pkg;

    localparam int STORE_ADDR_W = 10;
    localparam int STORE_DEPTH  = 1 << STORE_ADDR_W;

    localparam logic [7:0]  ERASED_BYTE     = 8'hFF;
    localparam logic [2:0]  ENABLE_WINDOW   = 3'd4;
    localparam logic [15:0] PROGRAM_CYCLES  = 16'd64;

    localparam logic [1:0] KIND_IDLE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] SEL_CTRL = 2'd0;
    localparam logic [1:0] SEL_ADDR = 2'd1;
    localparam logic [1:0] SEL_DATA = 2'd2;

    // Control register bit positions
    localparam int CTRL_READ   = 0;
    localparam int CTRL_WRITE  = 1;
    localparam int CTRL_MASTER = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] reg_select;
        logic [9:0] write_value;
    } req_t;

    typedef struct packed {
        logic [9:0] read_data;
        logic       busy_res;
        logic       store_done;
    } rsp_t;

    typedef struct packed {
        logic                    en;
        logic [STORE_ADDR_W-1:0] idx;
        logic [7:0]              data;
    } mem_wr_t;

endpackage

// ----- hw/rtl/eeprom_register_controller.sv -----
// Top level of the EEPROM register controller: register file, program timer, byte store.
//
// The block models a byte-wide EEPROM reached through a control, an address and a
// data register; each request transfer is one CPU cycle (idle tick, register read or
// register write) and returns exactly one response transfer. After reset the byte
// store is erased to 0xFF by a sweep over all 1024 addresses, one byte per cycle;
// req_ready stays low through the sweep and until the state register leaves ST_CLEAR.
// After that a request passes through ST_IDLE and ST_EXEC: in the cycle it is
// taken the byte at the current address is read through the registered read port of the
// store, and in ST_EXEC the step executes (timer, window, register access, possible commit
// to the store) and the response is loaded into the output register. req_ready
// returns high in the cycle after that, so a new request is taken only once the last
// one has executed. A response left waiting holds the block in ST_EXEC only if a
// second response is ready to be loaded.
module eeprom_register_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  erc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output erc_pkg::rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // architectural registers
    logic [9:0]  address_reg, address_next;
    logic [7:0]  data_reg, data_next;
    logic [2:0]  window_reg, window_next;
    logic        busy_reg, busy_next;
    logic [15:0] timer_reg, timer_next;

    // captured request and response register
    erc_pkg::req_t item_reg;
    erc_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg;

    logic             mem_ready;
    logic [7:0]       mem_rdata;
    erc_pkg::mem_wr_t mem_wr;
    logic             exec_fire;
    logic             commit;

    erc_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd_idx  (address_reg[erc_pkg::STORE_ADDR_W-1:0]),
        .rd_data (mem_rdata),
        .ready   (mem_ready)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign exec_fire = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // One step of the register model
    always_comb
    begin
        logic       open_v;
        logic [7:0] strobe_byte;

        address_next = address_reg;
        data_next    = data_reg;
        window_next  = window_reg;
        busy_next    = busy_reg;
        timer_next   = timer_reg;
        commit       = 1'b0;
        rsp_next     = '0;

        // program timer runs first; commit when it hits zero
        if (busy_reg)
        begin
            if (timer_reg != 16'd0)
                timer_next = timer_reg - 16'd1;
            if (timer_next == 16'd0)
            begin
                commit    = 1'b1;
                busy_next = 1'b0;
            end
        end

        open_v = (window_reg != 3'd0);
        if (open_v)
            window_next = window_reg - 3'd1;

        // a commit this step lands at the same address, so forward it
        strobe_byte = commit ? data_reg : mem_rdata;

        case (item_reg.kind)
            erc_pkg::KIND_WRITE:
            begin
                unique case (item_reg.reg_select)
                    erc_pkg::SEL_CTRL:
                    begin
                        if (item_reg.write_value[erc_pkg::CTRL_READ] && !busy_next)
                            data_next = strobe_byte;
                        if (item_reg.write_value[erc_pkg::CTRL_WRITE] && open_v && !busy_next)
                        begin
                            busy_next  = 1'b1;
                            timer_next = erc_pkg::PROGRAM_CYCLES;
                        end
                        if (item_reg.write_value[erc_pkg::CTRL_MASTER])
                            window_next = erc_pkg::ENABLE_WINDOW;
                    end
                    erc_pkg::SEL_ADDR:
                    begin
                        if (!busy_next)
                            address_next = item_reg.write_value;
                    end
                    erc_pkg::SEL_DATA:
                        data_next = item_reg.write_value[7:0];
                    default: ;
                endcase
            end
            erc_pkg::KIND_READ:
            begin
                unique case (item_reg.reg_select)
                    erc_pkg::SEL_CTRL:
                        rsp_next.read_data = {7'd0, window_next != 3'd0, busy_next, 1'b0};
                    erc_pkg::SEL_ADDR:
                        rsp_next.read_data = address_next;
                    erc_pkg::SEL_DATA:
                        rsp_next.read_data = {2'd0, data_next};
                    default: ;
                endcase
            end
            default: ;
        endcase

        rsp_next.busy_res   = busy_next;
        rsp_next.store_done = commit;
    end

    always_comb
    begin
        mem_wr.en   = exec_fire && commit;
        mem_wr.idx  = address_reg[erc_pkg::STORE_ADDR_W-1:0];
        mem_wr.data = data_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (mem_ready) state_next = ST_IDLE;
            ST_IDLE:  if (req_valid) state_next = ST_EXEC;
            ST_EXEC:  if (exec_fire) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            address_reg   <= '0;
            data_reg      <= '0;
            window_reg    <= '0;
            busy_reg      <= 1'b0;
            timer_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                address_reg   <= address_next;
                data_reg      <= data_next;
                window_reg    <= window_next;
                busy_reg      <= busy_next;
                timer_reg     <= timer_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            item_reg <= req;
        if (exec_fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // no request is taken before the erase sweep has finished
    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !mem_ready |-> !req_ready)
        else $error("request taken during erase sweep");

    // a newly started program operation loads the full timer
    a_timer_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> timer_reg == erc_pkg::PROGRAM_CYCLES)
        else $error("program timer not loaded on start");

    // window never exceeds its opening length
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        window_reg <= erc_pkg::ENABLE_WINDOW)
        else $error("enable window out of range");

    // the store is written only while a program operation completes
    a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> busy_reg && exec_fire)
        else $error("store written outside a commit");

endmodule

// ----- hw/rtl/erc_mem.sv -----
// Byte store with a registered read and an erase sweep after reset.
module erc_mem (
    input  logic                             clk,
    input  logic                             rst_n,
    input  erc_pkg::mem_wr_t                 wr,
    input  logic [erc_pkg::STORE_ADDR_W-1:0] rd_idx,
    output logic [7:0]                       rd_data,
    output logic                             ready
);

    logic [7:0] mem [erc_pkg::STORE_DEPTH];

    logic                             clearing_reg;
    logic [erc_pkg::STORE_ADDR_W-1:0] clr_cnt_reg;
    logic [7:0]                       rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == erc_pkg::STORE_ADDR_W'(erc_pkg::STORE_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    // erase sweep owns the write port until done
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_cnt_reg] <= erc_pkg::ERASED_BYTE;
        else if (wr.en)
            mem[wr.idx] <= wr.data;
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule
